[rtl/terminal_cell_escape_encoder_assert.svh]
// Assertion macros used by the checker file of the escape encoder.
`ifndef TERMINAL_CELL_ESCAPE_ENCODER_ASSERT_SVH
`define TERMINAL_CELL_ESCAPE_ENCODER_ASSERT_SVH

// Checked only while the block is out of reset.
`define TCE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

// Checked on every rising clock edge, reset included.
`define TCE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

[rtl/tce_pkg.sv]
// Shared types, constants and the decimal helper function of the escape encoder.
`timescale 1ns / 1ps
package tce_pkg;

    localparam int GRID_SIZE   = 1024;
    localparam int COL_W       = $clog2(2 * GRID_SIZE);
    localparam int POS_W       = 10;
    localparam int DEC_W       = 11;
    localparam int COLOR_W     = 25;
    localparam int IN_TDATA_W  = 112;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int SLOT_W      = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_AREA_LEFT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_TOP  = 1'b1;

    localparam logic [SLOT_W-1:0] SL_SGR    = 6'd12;
    localparam logic [SLOT_W-1:0] SL_FG     = 6'd24;
    localparam logic [SLOT_W-1:0] SL_BG     = 6'd41;
    localparam logic [SLOT_W-1:0] SL_GLY    = 6'd58;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 6'd61;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic        cup;
        logic [15:0] row_d;
        logic [15:0] col_d;
        logic        sty_chg;
        logic [3:0]  style;
        logic        fg_en;
        logic        fg_set;
        logic [35:0] fg_d;
        logic        bg_en;
        logic        bg_set;
        logic [35:0] bg_d;
        logic [31:0] gly;
        logic [1:0]  gly_n;
    } t_job;

    // Four decimal digits of a value below 2048, thousands digit on top.
    function automatic logic [15:0] to_dec(input logic [DEC_W-1:0] v);
        logic [DEC_W-1:0] r;
        logic [3:0]       d3;
        logic [3:0]       d2;
        logic [3:0]       d1;
        r  = v;
        d3 = 4'd0;
        d2 = 4'd0;
        d1 = 4'd0;
        if (r >= 11'd2000) begin
            d3 = 4'd2;
            r  = r - 11'd2000;
        end else if (r >= 11'd1000) begin
            d3 = 4'd1;
            r  = r - 11'd1000;
        end
        for (int i = 1; i <= 9; i++) begin
            if (r >= 11'(i * 100)) d2 = 4'(i);
        end
        r = r - (11'(d2) * 11'd100);
        for (int i = 1; i <= 9; i++) begin
            if (r >= 11'(i * 10)) d1 = 4'(i);
        end
        r = r - (11'(d1) * 11'd10);
        return {d3, d2, d1, r[3:0]};
    endfunction

endpackage

[rtl/tce_front.sv]
// Front part: takes cell beats, tracks cursor and attributes, builds jobs.
`timescale 1ns / 1ps
module tce_front
    import tce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic                  i_tuser,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [POS_W-1:0]   r_area_left;
    logic [POS_W-1:0]   r_area_top;
    logic               r_pos_valid;
    logic [COL_W-1:0]   r_next_col;
    logic [POS_W-1:0]   r_last_row;
    logic [3:0]         r_last_style;
    logic [COLOR_W-1:0] r_last_fg;
    logic [COLOR_W-1:0] r_last_bg;

    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [3:0]         style;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [31:0]        gly;
    logic [2:0]         rw;
    logic               pv;
    logic [3:0]         ls;
    logic [COLOR_W-1:0] lf;
    logic [COLOR_W-1:0] lb;
    logic               blank;
    logic [COL_W-1:0]   n_next_col;
    logic [15:0]        fr;
    logic [15:0]        fgr;
    logic [15:0]        fb;
    logic [15:0]        br;
    logic [15:0]        bgr;
    logic [15:0]        bb;

    assign col   = i_tdata[9:0];
    assign row   = i_tdata[19:10];
    assign style = i_tdata[23:20];
    assign fg    = i_tdata[48:24];
    assign bg    = i_tdata[73:49];
    assign gly   = i_tdata[105:74];
    assign rw    = i_tdata[108:106];

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        pv    = r_pos_valid && !i_tuser;
        ls    = i_tuser ? 4'd0 : r_last_style;
        lf    = (i_tuser || style != ls) ? '0 : r_last_fg;
        lb    = (i_tuser || style != ls) ? '0 : r_last_bg;
        blank = (gly[7:0] <= CH_SPACE) || (gly[7:0] == CH_DEL);
        fr    = to_dec({3'b000, fg[23:16]});
        fgr   = to_dec({3'b000, fg[15:8]});
        fb    = to_dec({3'b000, fg[7:0]});
        br    = to_dec({3'b000, bg[23:16]});
        bgr   = to_dec({3'b000, bg[15:8]});
        bb    = to_dec({3'b000, bg[7:0]});
        n_next_col = COL_W'({1'b0, col}) + COL_W'((rw == 3'd0) ? 3'd1 : rw);

        o_job.cup     = !pv || (COL_W'(col) != r_next_col) || (row != r_last_row);
        o_job.row_d   = to_dec(DEC_W'(r_area_top) + DEC_W'(row) + 11'd1);
        o_job.col_d   = to_dec(DEC_W'(r_area_left) + DEC_W'(col) + 11'd1);
        o_job.sty_chg = style != ls;
        o_job.style   = style;
        o_job.fg_en   = fg != lf;
        o_job.fg_set  = fg[24];
        o_job.fg_d    = {fr[11:0], fgr[11:0], fb[11:0]};
        o_job.bg_en   = bg != lb;
        o_job.bg_set  = bg[24];
        o_job.bg_d    = {br[11:0], bgr[11:0], bb[11:0]};
        if (blank) begin
            o_job.gly   = {24'd0, CH_SPACE};
            o_job.gly_n = 2'd0;
        end else begin
            o_job.gly   = gly;
            if (gly[15:8] == 8'd0) begin
                o_job.gly_n = 2'd0;
            end else if (gly[23:16] == 8'd0) begin
                o_job.gly_n = 2'd1;
            end else if (gly[31:24] == 8'd0) begin
                o_job.gly_n = 2'd2;
            end else begin
                o_job.gly_n = 2'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left  <= '0;
            r_area_top   <= '0;
            r_pos_valid  <= 1'b0;
            r_next_col   <= '0;
            r_last_row   <= '0;
            r_last_style <= '0;
            r_last_fg    <= '0;
            r_last_bg    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_AREA_LEFT: r_area_left <= i_cfg_data;
                    REG_AREA_TOP:  r_area_top  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_pos_valid  <= 1'b1;
                r_next_col   <= n_next_col;
                r_last_row   <= row;
                r_last_style <= style;
                r_last_fg    <= fg;
                r_last_bg    <= bg;
            end
        end
    end

endmodule

[rtl/tce_queue.sv]
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps
module tce_queue
    import tce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job                     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] r_count;

    assign o_full  = r_count == ($bits(r_count))'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/tce_back.sv]
// Back part: walks the byte slots of one job and drives the output register.
`timescale 1ns / 1ps
module tce_back
    import tce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    t_job              r_job;
    logic              r_valid;
    logic [7:0]        r_data;
    logic              r_last;

    logic              adv;
    logic              en;
    logic [7:0]        ch;
    logic              last;
    logic [SLOT_W-1:0] k;
    logic [8:0]        cs;
    logic              sgr_any;
    logic              sty_end;

    function automatic logic [8:0] digit(input logic [11:0] d, input logic [1:0] p,
                                         input logic on);
        logic [8:0] res;
        res = '0;
        unique case (p)
            2'd0:    res = {on && d[11:8] != 4'd0, 4'h3, d[11:8]};
            2'd1:    res = {on && d[11:4] != 8'd0, 4'h3, d[7:4]};
            default: res = {on, 4'h3, d[3:0]};
        endcase
        return res;
    endfunction

    function automatic logic [8:0] color_slot(input logic [4:0] s, input logic [7:0] lead,
                                              input logic seg, input logic set,
                                              input logic [35:0] d, input logic term);
        logic [8:0] res;
        logic       on;
        on  = seg && set;
        res = '0;
        unique case (s)
            5'd0:  res = {seg, lead};
            5'd1:  res = {seg, set ? 8'h38 : 8'h39};
            5'd2:  res = {seg, (!set && term) ? CH_M : CH_SEMI};
            5'd3:  res = {on, 8'h32};
            5'd4, 5'd8, 5'd12: res = {on, CH_SEMI};
            5'd5:  res = digit(d[35:24], 2'd0, on);
            5'd6:  res = digit(d[35:24], 2'd1, on);
            5'd7:  res = digit(d[35:24], 2'd2, on);
            5'd9:  res = digit(d[23:12], 2'd0, on);
            5'd10: res = digit(d[23:12], 2'd1, on);
            5'd11: res = digit(d[23:12], 2'd2, on);
            5'd13: res = digit(d[11:0], 2'd0, on);
            5'd14: res = digit(d[11:0], 2'd1, on);
            5'd15: res = digit(d[11:0], 2'd2, on);
            5'd16: res = {on, term ? CH_M : CH_SEMI};
            default: res = '0;
        endcase
        return res;
    endfunction

    always_comb begin
        en      = 1'b0;
        ch      = 8'd0;
        last    = 1'b0;
        k       = '0;
        cs      = '0;
        sgr_any = r_job.sty_chg || r_job.fg_en || r_job.bg_en;
        sty_end = r_job.sty_chg && !r_job.fg_en && !r_job.bg_en;
        if (r_slot < SL_SGR) begin
            k = r_slot;
            unique case (k[3:0])
                4'd0:  cs = {r_job.cup, CH_ESC};
                4'd1:  cs = {r_job.cup, CH_LBR};
                4'd2:  cs = {r_job.cup && r_job.row_d[15:12] != 4'd0, 4'h3, r_job.row_d[15:12]};
                4'd3:  cs = {r_job.cup && r_job.row_d[15:8] != 8'd0, 4'h3, r_job.row_d[11:8]};
                4'd4:  cs = {r_job.cup && r_job.row_d[15:4] != 12'd0, 4'h3, r_job.row_d[7:4]};
                4'd5:  cs = {r_job.cup, 4'h3, r_job.row_d[3:0]};
                4'd6:  cs = {r_job.cup, CH_SEMI};
                4'd7:  cs = {r_job.cup && r_job.col_d[15:12] != 4'd0, 4'h3, r_job.col_d[15:12]};
                4'd8:  cs = {r_job.cup && r_job.col_d[15:8] != 8'd0, 4'h3, r_job.col_d[11:8]};
                4'd9:  cs = {r_job.cup && r_job.col_d[15:4] != 12'd0, 4'h3, r_job.col_d[7:4]};
                4'd10: cs = {r_job.cup, 4'h3, r_job.col_d[3:0]};
                4'd11: cs = {r_job.cup, CH_H};
                default: cs = '0;
            endcase
        end else if (r_slot < SL_FG) begin
            k = r_slot - SL_SGR;
            unique case (k[3:0])
                4'd0:  cs = {sgr_any, CH_ESC};
                4'd1:  cs = {sgr_any, CH_LBR};
                4'd2:  cs = {r_job.sty_chg, 8'h30};
                4'd3:  cs = {r_job.sty_chg,
                             (sty_end && r_job.style == 4'd0) ? CH_M : CH_SEMI};
                4'd4:  cs = {r_job.sty_chg && r_job.style[0], 8'h31};
                4'd5:  cs = {r_job.sty_chg && r_job.style[0],
                             (sty_end && r_job.style[3:1] == 3'd0) ? CH_M : CH_SEMI};
                4'd6:  cs = {r_job.sty_chg && r_job.style[1], 8'h33};
                4'd7:  cs = {r_job.sty_chg && r_job.style[1],
                             (sty_end && r_job.style[3:2] == 2'd0) ? CH_M : CH_SEMI};
                4'd8:  cs = {r_job.sty_chg && r_job.style[2], 8'h34};
                4'd9:  cs = {r_job.sty_chg && r_job.style[2],
                             (sty_end && !r_job.style[3]) ? CH_M : CH_SEMI};
                4'd10: cs = {r_job.sty_chg && r_job.style[3], 8'h39};
                4'd11: cs = {r_job.sty_chg && r_job.style[3], sty_end ? CH_M : CH_SEMI};
                default: cs = '0;
            endcase
        end else if (r_slot < SL_BG) begin
            k  = r_slot - SL_FG;
            cs = color_slot(k[4:0], 8'h33, r_job.fg_en, r_job.fg_set, r_job.fg_d,
                            !r_job.bg_en);
        end else if (r_slot < SL_GLY) begin
            k  = r_slot - SL_BG;
            cs = color_slot(k[4:0], 8'h34, r_job.bg_en, r_job.bg_set, r_job.bg_d, 1'b1);
        end else begin
            k    = r_slot - SL_GLY;
            cs   = {k[1:0] <= r_job.gly_n, r_job.gly[8*k[1:0] +: 8]};
            last = k[1:0] == r_job.gly_n;
        end
        en = cs[8];
        ch = cs[7:0];
    end

    assign adv      = !r_valid || i_tready;
    assign o_pop    = !r_busy && !i_empty;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_slot <= '0;
            end
            if (adv) begin
                r_valid <= r_busy && en;
                if (r_busy) begin
                    r_slot <= r_slot + 1'b1;
                    if (r_slot == SLOT_LAST) r_busy <= 1'b0;
                end
            end
        end
        if (o_pop) r_job <= i_job;
        if (adv) begin
            r_data <= ch;
            r_last <= last;
        end
    end

endmodule

[rtl/terminal_cell_escape_encoder.sv]
// Top level of the terminal cell escape encoder.
//
// Cells enter on the s channel: tdata holds column, row, style, fg_color,
// bg_rgb, glyph and render_width, tuser holds frame_start. Each cell
// produces 1 to 62 bytes on the m channel, with tlast on the final byte.
// The area_left and area_top registers are written through the plain write
// port and should change only while the block is idle.
// The front part updates cursor and attribute tracking as a beat is taken
// and places a job in a two-entry queue. The back part walks 62 fixed byte
// slots per job, one slot per cycle, so a cell holds the back part for the
// whole walk however many bytes it yields; the slot walk sets the rate. A
// cursor-move cell shows its first byte after the queue, the job and output
// registers; a glyph-only cell shows it after all earlier slots. A receiver
// stall freezes the slot walk; input beats are still taken until the queue
// is full. Reset is synchronous and active low, clears tracking, the
// registers and the queue, and leaves the block ready for input.
`timescale 1ns / 1ps
module terminal_cell_escape_encoder
    import tce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // column, row, style, fg_color, bg_rgb, glyph, render_width, zero pad
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    // frame_start
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_byte
    output logic [7:0]            o_m_tdata,
    output logic                  o_m_tlast
);

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    tce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_tdata    (i_s_tdata),
        .i_tuser    (i_s_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    tce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    tce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

[rtl/tce_checker.sv]
// Port-level checks of the escape encoder and their binding.
`timescale 1ns / 1ps
`include "terminal_cell_escape_encoder_assert.svh"
module tce_checker
    import tce_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    `TCE_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable({o_m_tdata, o_m_tlast}))
    `TCE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_tvalid)
    `TCE_ASSERT_ALWAYS(a_reset_ready, i_clk, !i_rst_n |=> o_s_tready)
    `TCE_ASSERT(a_ready_drop, i_clk, i_rst_n, $fell(o_s_tready) |-> $past(i_s_tvalid && o_s_tready))

endmodule

bind terminal_cell_escape_encoder tce_checker u_tce_checker (.*);
